// ===== hdl/rsi_pkg.sv =====
// shared types and constants for the ray-sphere intersection core
package rsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;
    localparam int DW        = 18;
    localparam int RW        = 31;
    localparam int BW        = 8;
    localparam int DIFF_W    = CW + 1;
    localparam int DOT_W     = DIFF_W + DW + 2;
    localparam int H_W       = DOT_W - FRAC_BITS + 1;
    localparam int SQ_W      = 2 * DIFF_W + 2;
    localparam int C_W       = SQ_W + 1;
    localparam int HH_W      = 2 * H_W;
    localparam int Q_W       = HH_W + 1;
    localparam int RAD_W     = HH_W;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int FIN_W     = ROOT_W + 3;
    localparam int AW        = 5;

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_BIAS     = 3'd4;

    localparam logic [RW-1:0] RADIUS_RESET = RW'(65536);
    localparam logic [BW-1:0] BIAS_RESET   = BW'(1);
    localparam logic [CW-1:0] MISS_DIST    = CW'(-(64'sd1 <<< FRAC_BITS));

    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic signed [H_W-1:0] h;
    } rsi_side_t;

endpackage

// ===== hdl/rsi_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module rsi_isqrt
    import rsi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  rsi_side_t           side_in,
    input  logic [RAD_W-1:0]    rad_in,
    output rsi_side_t           side_out,
    output logic [ROOT_W-1:0]   root_out
);

    rsi_side_t           side_reg [1:ROOT_W];
    logic [RAD_W-1:0]    rad_reg  [1:ROOT_W];
    logic [REM_W-1:0]    rem_reg  [1:ROOT_W];
    logic [ROOT_W-1:0]   root_reg [1:ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_step
        rsi_side_t        side_cur;
        logic [RAD_W-1:0] rad_cur;
        logic [REM_W-1:0] rem_cur;
        logic [ROOT_W-1:0] root_cur;
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             take;
        logic [REM_W-1:0] rem_next;
        logic [ROOT_W-1:0] root_next;

        if (j == 0) begin : g_first
            assign side_cur = side_in;
            assign rad_cur  = rad_in;
            assign rem_cur  = '0;
            assign root_cur = '0;
        end else begin : g_later
            assign side_cur = side_reg[j];
            assign rad_cur  = rad_reg[j];
            assign rem_cur  = rem_reg[j];
            assign root_cur = root_reg[j];
        end

        always_comb
        begin
            rem_sh    = {rem_cur, rad_cur[RAD_W-1 -: 2]};
            trial     = {2'b00, root_cur, 2'b01};
            take      = rem_sh >= trial;
            rem_next  = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_next = {root_cur[ROOT_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                side_reg[j+1] <= '0;
            end else if (en) begin
                side_reg[j+1] <= side_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                rad_reg[j+1]      <= {rad_cur[RAD_W-3:0], 2'b00};
                rem_reg[j+1]      <= rem_next;
                root_reg[j+1]     <= root_next;
            end
        end
    end

    assign side_out = side_reg[ROOT_W];
    assign root_out = root_reg[ROOT_W];

endmodule

// ===== hdl/ray_sphere_intersection_core.sv =====
// ray-sphere intersection core: apb registers and the ray test pipeline
// throughput: one item per cycle; the whole pipeline halts while a result waits
// the square root takes one stage per result bit and sets most of the depth
// reset clears all valid bits; center 0, radius 1.0, bias 1 lsb
module ray_sphere_intersection_core
    import rsi_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    input  logic [151:0]    s_axis_tdata,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // distance
    output logic [31:0]     m_axis_tdata,
    // hit
    output logic [0:0]      m_axis_tuser,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [AW-1:0]   paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [RW-1:0]        rad_reg;
    logic [BW-1:0]        bias_reg;
    logic                 wr_en;
    logic [2:0]           widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = paddr[AW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            cz_reg   <= '0;
            rad_reg  <= RADIUS_RESET;
            bias_reg <= BIAS_RESET;
        end else if (wr_en) begin
            unique case (widx)
                REG_CENTER_X: cx_reg   <= pwdata;
                REG_CENTER_Y: cy_reg   <= pwdata;
                REG_CENTER_Z: cz_reg   <= pwdata;
                REG_RADIUS:   rad_reg  <= pwdata[RW-1:0];
                REG_BIAS:     bias_reg <= pwdata[BW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_CENTER_X: prdata = cx_reg;
            REG_CENTER_Y: prdata = cy_reg;
            REG_CENTER_Z: prdata = cz_reg;
            REG_RADIUS:   prdata = {1'b0, rad_reg};
            REG_BIAS:     prdata = {24'd0, bias_reg};
            default:      prdata = '0;
        endcase
    end

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [CW-1:0] ox, oy, oz;
    logic signed [DW-1:0] ux, uy, uz;
    assign ox = s_axis_tdata[31:0];
    assign oy = s_axis_tdata[63:32];
    assign oz = s_axis_tdata[95:64];
    assign ux = s_axis_tdata[113:96];
    assign uy = s_axis_tdata[131:114];
    assign uz = s_axis_tdata[149:132];

    // stage 1: offsets from the center
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic signed [DW-1:0]     ux1_reg, uy1_reg, uz1_reg;

    // stage 2: products
    logic                      v2_reg;
    logic signed [2*DIFF_W-1:0] pxx_reg, pyy_reg, pzz_reg;
    logic signed [DIFF_W+DW-1:0] px_reg, py_reg, pz_reg;
    logic [2*RW-1:0]           rr_reg;

    // stage 3: h and c
    logic                  v3_reg;
    logic signed [H_W-1:0] h3_reg;
    logic signed [C_W-1:0] c3_reg;

    // stage 4: h squared
    logic                   v4_reg;
    logic signed [H_W-1:0]  h4_reg;
    logic signed [C_W-1:0]  c4_reg;
    logic signed [HH_W-1:0] hh4_reg;

    // stage 5: quarter discriminant
    rsi_side_t          side5_reg;
    logic [RAD_W-1:0]   q5_reg;

    logic signed [DOT_W-1:0] dot_next;
    logic signed [DOT_W-1:0] dot_rnd;
    logic signed [C_W-1:0]   c_next;
    logic signed [Q_W-1:0]   q_next;

    always_comb
    begin
        dot_next = DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
        dot_rnd  = dot_next + (DOT_W'(1) <<< (FRAC_BITS - 1));
        c_next   = C_W'(pxx_reg) + C_W'(pyy_reg) + C_W'(pzz_reg)
                   - C_W'(signed'({1'b0, rr_reg}));
        q_next   = Q_W'(hh4_reg) - Q_W'(c4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            side5_reg       <= '0;
        end else if (en) begin
            v1_reg          <= s_axis_tvalid;
            v2_reg          <= v1_reg;
            v3_reg          <= v2_reg;
            v4_reg          <= v3_reg;
            side5_reg.valid <= v4_reg;
            side5_reg.h     <= h4_reg;
            side5_reg.hit   <= !q_next[Q_W-1] && (q_next != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            dx1_reg <= DIFF_W'(ox) - DIFF_W'(cx_reg);
            dy1_reg <= DIFF_W'(oy) - DIFF_W'(cy_reg);
            dz1_reg <= DIFF_W'(oz) - DIFF_W'(cz_reg);
            ux1_reg <= ux;
            uy1_reg <= uy;
            uz1_reg <= uz;

            pxx_reg <= dx1_reg * dx1_reg;
            pyy_reg <= dy1_reg * dy1_reg;
            pzz_reg <= dz1_reg * dz1_reg;
            px_reg  <= dx1_reg * ux1_reg;
            py_reg  <= dy1_reg * uy1_reg;
            pz_reg  <= dz1_reg * uz1_reg;
            rr_reg  <= rad_reg * rad_reg;

            h3_reg  <= H_W'(dot_rnd >>> FRAC_BITS);
            c3_reg  <= c_next;

            h4_reg  <= h3_reg;
            c4_reg  <= c3_reg;
            hh4_reg <= h3_reg * h3_reg;

            q5_reg        <= (!q_next[Q_W-1]) ? q_next[RAD_W-1:0] : '0;
        end
    end

    rsi_side_t         side_sq;
    logic [ROOT_W-1:0] s_sq;

    rsi_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (side5_reg),
        .rad_in   (q5_reg),
        .side_out (side_sq),
        .root_out (s_sq)
    );

    // both candidate roots
    logic                    v6_reg;
    logic                    hit6_reg;
    logic signed [FIN_W-1:0] near6_reg, far6_reg;

    logic signed [FIN_W-1:0] sqx, hx, bx;
    always_comb
    begin
        sqx = FIN_W'(signed'({1'b0, s_sq}));
        hx  = FIN_W'(side_sq.h);
        bx  = FIN_W'(signed'({1'b0, bias_reg}));
    end

    // output register
    logic            out_v_reg;
    logic            out_hit_reg;
    logic [CW-1:0]   out_dist_reg;
    logic signed [FIN_W-1:0] pick;
    logic [CW-1:0]   dist_next;

    always_comb
    begin
        pick = (near6_reg > 0) ? near6_reg : far6_reg;
        if (pick > FIN_W'(64'sd2147483647)) begin
            dist_next = 32'h7FFF_FFFF;
        end else if (pick < -FIN_W'(64'sd2147483648)) begin
            dist_next = 32'h8000_0000;
        end else begin
            dist_next = pick[CW-1:0];
        end
        if (!hit6_reg) begin
            dist_next = MISS_DIST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v6_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            v6_reg    <= side_sq.valid;
            out_v_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            hit6_reg     <= side_sq.hit;
            near6_reg    <= -hx - sqx - bx;
            far6_reg     <= -hx + sqx - bx;
            out_hit_reg  <= hit6_reg;
            out_dist_reg <= dist_next;
        end
    end

    assign m_axis_tvalid   = out_v_reg;
    assign m_axis_tdata    = out_dist_reg;
    assign m_axis_tuser[0] = out_hit_reg;

endmodule

// ===== hdl/rsi_checker.sv =====
// port-level checks for the ray-sphere intersection core
module rsi_checker
    import rsi_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a miss always reports minus one
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == MISS_DIST)
        else $error("miss distance wrong");

    // input side halts exactly when a result is stuck
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready mismatch");

endmodule

bind ray_sphere_intersection_core rsi_checker u_rsi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/testbench.sv =====
// self-checking testbench for the ray-sphere intersection core
module testbench;
    import rsi_pkg::*;

    typedef struct {
        logic signed [31:0] ox, oy, oz;
        logic signed [17:0] ux, uy, uz;
    } ray_t;

    typedef struct {
        logic        hit;
        logic [31:0] distance;
    } hit_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    logic [151:0]   s_axis_tdata = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    // distance
    logic [31:0]    m_axis_tdata;
    // hit
    logic [0:0]     m_axis_tuser;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [AW-1:0]  paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    ray_sphere_intersection_core uut (.*);

    // local copy of the sphere registers
    longint   sph_cx, sph_cy, sph_cz;
    logic [RW-1:0] sph_r;
    logic [BW-1:0] sph_bias;

    hit_t   pending_hits[$];
    int     mismatches = 0;
    int     rays_sent = 0;
    int     results_seen = 0;
    int     hits_seen = 0;
    int     idle_cycles = 0;
    int     stall_mode = 0;
    int     gap_mode = 0;
    int     burst_left = 0;
    int     cyc = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] isqrt128(input logic [127:0] n);
        logic [127:0] r, b;
        r = '0;
        b = 128'h1 << 126;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[63:0];
    endfunction

    function automatic hit_t predict_hit(input ray_t ray);
        longint dx, dy, dz, dot, h, s, root;
        logic signed [127:0] wx, wy, wz, wh, wr, c, q;
        hit_t res;
        dx = longint'(ray.ox) - sph_cx;
        dy = longint'(ray.oy) - sph_cy;
        dz = longint'(ray.oz) - sph_cz;
        dot = dx * longint'(ray.ux) + dy * longint'(ray.uy) + dz * longint'(ray.uz);
        h = (dot + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        wx = dx;
        wy = dy;
        wz = dz;
        wh = h;
        wr = {97'b0, sph_r};
        c = wx * wx + wy * wy + wz * wz - wr * wr;
        q = wh * wh - c;
        if (q <= 0) begin
            res.hit = 1'b0;
            res.distance = MISS_DIST;
            return res;
        end
        s = longint'(isqrt128(q));
        root = -h - s - longint'(sph_bias);
        if (root <= 0) root = -h + s - longint'(sph_bias);
        if (root > 64'sd2147483647) root = 64'sd2147483647;
        if (root < -64'sd2147483648) root = -64'sd2147483648;
        res.hit = 1'b1;
        res.distance = root[31:0];
        return res;
    endfunction

    // receiver stall pattern
    always @(negedge clk) begin
        cyc <= cyc + 1;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 99) >= 40);
            2: m_axis_tready <= ((cyc % 13) >= 5);
            default: m_axis_tready <= ($urandom_range(0, 99) >= 85);
        endcase
    end

    // result checker
    always @(posedge clk) begin
        hit_t exp_h;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result hit=%0b dist=%h", m_axis_tuser, m_axis_tdata);
            end else begin
                exp_h = pending_hits.pop_front();
                if (exp_h.hit) hits_seen++;
                if (exp_h.hit !== m_axis_tuser[0] || exp_h.distance !== m_axis_tdata) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hit=%0b dist=%h got hit=%0b dist=%h",
                                 exp_h.hit, exp_h.distance, m_axis_tuser, m_axis_tdata);
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_ray(input ray_t ray);
        hit_t exp_h;
        int gap;
        exp_h = predict_hit(ray);
        if (gap_mode != 0 && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, gap_mode == 1 ? 4 : 12);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        if (burst_left > 0) burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, ray.uz, ray.uy, ray.ux, ray.oz, ray.oy, ray.ox};
        do @(posedge clk); while (!s_axis_tready);
        pending_hits.push_back(exp_h);
        rays_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CENTER_X: sph_cx = longint'($signed(value));
            REG_CENTER_Y: sph_cy = longint'($signed(value));
            REG_CENTER_Z: sph_cz = longint'($signed(value));
            REG_RADIUS:   sph_r = value[RW-1:0];
            REG_BIAS:     sph_bias = value[BW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_sphere(input longint cx, cy, cz, input logic [31:0] r, bias);
        write_reg(REG_CENTER_X, cx[31:0]);
        write_reg(REG_CENTER_Y, cy[31:0]);
        write_reg(REG_CENTER_Z, cz[31:0]);
        write_reg(REG_RADIUS, r);
        write_reg(REG_BIAS, bias);
    endtask

    function automatic ray_t make_ray(input longint ox, oy, oz, input int ux, uy, uz);
        ray_t ray;
        ray.ox = ox[31:0];
        ray.oy = oy[31:0];
        ray.oz = oz[31:0];
        ray.ux = ux[17:0];
        ray.uy = uy[17:0];
        ray.uz = uz[17:0];
        return ray;
    endfunction

    function automatic ray_t noise_ray();
        ray_t ray;
        ray.ox = $urandom;
        ray.oy = $urandom;
        ray.oz = $urandom;
        ray.ux = 18'($urandom);
        ray.uy = 18'($urandom);
        ray.uz = 18'($urandom);
        return ray;
    endfunction

    // origin near the sphere, unit direction mostly aimed near the center
    function automatic ray_t aimed_ray();
        real r, ox, oy, oz, vx, vy, vz, len;
        r = real'(sph_r) + 1.0;
        ox = (real'($urandom_range(0, 8000)) - 4000.0) / 1000.0 * r;
        oy = (real'($urandom_range(0, 8000)) - 4000.0) / 1000.0 * r;
        oz = (real'($urandom_range(0, 8000)) - 4000.0) / 1000.0 * r;
        vx = -ox + (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * r;
        vy = -oy + (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * r;
        vz = -oz + (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * r;
        if ($urandom_range(0, 5) == 0) begin
            vx = -vx;
            vy = -vy;
            vz = -vz;
        end
        len = $sqrt(vx * vx + vy * vy + vz * vz);
        if (len == 0.0) begin
            vx = 1.0;
            len = 1.0;
        end
        return make_ray(sph_cx + longint'(ox), sph_cy + longint'(oy), sph_cz + longint'(oz),
                        int'(vx / len * 65536.0), int'(vy / len * 65536.0),
                        int'(vz / len * 65536.0));
    endfunction

    task automatic test_default_sphere();
        stall_mode = 0;
        gap_mode = 0;
        // straight hits along each axis
        send_ray(make_ray(-5 * 65536, 0, 0, 65536, 0, 0));
        send_ray(make_ray(0, 3 * 65536, 0, 0, -65536, 0));
        send_ray(make_ray(0, 0, -2 * 65536, 0, 0, 65536));
        // origin inside, far root
        send_ray(make_ray(0, 0, 0, 65536, 0, 0));
        // sphere behind the ray, negative far root
        send_ray(make_ray(5 * 65536, 0, 0, 65536, 0, 0));
        // tangent ray misses
        send_ray(make_ray(-5 * 65536, 65536, 0, 65536, 0, 0));
        // clear miss and zero direction
        send_ray(make_ray(-5 * 65536, 3 * 65536, 0, 65536, 0, 0));
        send_ray(make_ray(0, 0, 0, 0, 0, 0));
        // non-unit direction, most positive and negative codes
        send_ray(make_ray(-5 * 65536, 0, 0, 131071, 0, 0));
        send_ray(make_ray(-5 * 65536, 0, 0, -131072, -131072, -131072));
        send_ray(make_ray(-5 * 65536, 0, 0, 65536, 65536, 65536));
        // origin extremes
        send_ray(make_ray(64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff, -65536, 0, 0));
        send_ray(make_ray(-64'sh80000000, -64'sh80000000, -64'sh80000000, 65536, 0, 0));
        send_ray(make_ray(-64'sh80000000, 0, 0, 65536, 0, 0));
        wait_drained();
    endtask

    task automatic test_register_extremes();
        // huge radius, maximum bias, saturating distances
        set_sphere(0, 0, 0, 32'h7fffffff, 255);
        send_ray(make_ray(0, 0, 0, 65536, 0, 0));
        send_ray(make_ray(-64'sh80000000, 0, 0, 65536, 0, 0));
        send_ray(make_ray(64'sh7fffffff, 64'sh7fffffff, 0, -65536, 0, 0));
        wait_drained();
        // zero radius, zero bias, centers at the extremes
        set_sphere(64'sh7fffffff, -64'sh80000000, 64'sh7fffffff, 0, 0);
        send_ray(make_ray(0, 0, 0, 65536, 0, 0));
        send_ray(make_ray(64'sh7fffffff, -64'sh80000000, 64'sh7fffff00, 0, 0, 65536));
        send_ray(make_ray(-64'sh80000000, 64'sh7fffffff, -64'sh80000000, 131071, -131072, 131071));
        wait_drained();
    endtask

    task automatic test_random_rays(input int count, input int smode, input int gmode);
        longint cx, cy, cz;
        logic [31:0] r;
        stall_mode = smode;
        gap_mode = gmode;
        case ($urandom_range(0, 2))
            0: r = $urandom_range(1 << 10, 1 << 20);
            1: r = $urandom_range(1 << 16, 1 << 28);
            default: r = {1'b0, 31'($urandom)};
        endcase
        cx = longint'($signed(32'($urandom))) >>> $urandom_range(0, 8);
        cy = longint'($signed(32'($urandom))) >>> $urandom_range(0, 8);
        cz = longint'($signed(32'($urandom))) >>> $urandom_range(0, 8);
        set_sphere(cx, cy, cz, r, $urandom_range(0, 255));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) send_ray(noise_ray());
            else send_ray(aimed_ray());
        end
        wait_drained();
    endtask

    task automatic test_pause_until_drained();
        stall_mode = 3;
        gap_mode = 0;
        for (int i = 0; i < 65; i++) send_ray(aimed_ray());
        wait_drained();
        stall_mode = 1;
        for (int i = 0; i < 65; i++) send_ray(aimed_ray());
        wait_drained();
    endtask

    initial begin
        sph_cx = 0;
        sph_cy = 0;
        sph_cz = 0;
        sph_r = RADIUS_RESET;
        sph_bias = BIAS_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);
        test_default_sphere();
        test_register_extremes();
        test_random_rays(250, 0, 0);
        test_random_rays(250, 1, 1);
        test_random_rays(250, 2, 2);
        test_random_rays(250, 3, 1);
        test_pause_until_drained();
        $display("rays sent %0d, results checked %0d, hits %0d, mismatches %0d",
                 rays_sent, results_seen, hits_seen, mismatches);
        $display("covered default and extreme registers, tangent, inside and behind rays");
        if (mismatches == 0 && pending_hits.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
